// ===== hw/rtl/prt_pkg.sv =====
`timescale 1ns / 1ps
package prt_pkg;

    localparam int SMP_W = 24;
    localparam int WIDE_W = 27;
    localparam int COEF_W = 16;
    localparam int ADDR_W = 16;
    localparam int MEM_DEPTH = 42368;
    localparam logic [12:0] PREDELAY_MAX = 13'd4800;

    typedef logic signed [SMP_W-1:0] t_smp;
    typedef logic signed [WIDE_W-1:0] t_wide;
    typedef logic [COEF_W-1:0] t_coef;

    localparam t_wide SMP_HI = 27'sd8388607;
    localparam t_wide SMP_LO = -27'sd8388608;

    localparam logic [16:0] DD2_BIAS = 17'd9830;
    localparam logic [16:0] DD2_LO = 17'd16384;
    localparam logic [16:0] DD2_HI = 17'd32768;

    localparam logic [2:0] CFG_PREDELAY = 3'd0;
    localparam logic [2:0] CFG_PREFILT = 3'd1;
    localparam logic [2:0] CFG_DIFF_ONE = 3'd2;
    localparam logic [2:0] CFG_DIFF_TWO = 3'd3;
    localparam logic [2:0] CFG_DECAY = 3'd4;
    localparam logic [2:0] CFG_DECAY_DIFF = 3'd5;
    localparam logic [2:0] CFG_DAMPING = 3'd6;

    localparam logic [5:0] S_PD_WR = 6'd0;
    localparam logic [5:0] S_PD_RD = 6'd1;
    localparam logic [5:0] S_LP_IN = 6'd2;
    localparam logic [5:0] S_ID_FIRST = 6'd3;
    localparam logic [5:0] S_ID_LAST = 6'd10;
    localparam logic [5:0] S_H0 = 6'd11;
    localparam logic [5:0] S_H1 = 6'd18;
    localparam logic [5:0] S_H_END = 6'd24;
    localparam logic [5:0] S_TAP_RD = 6'd25;
    localparam logic [5:0] S_TAP_RD_END = 6'd38;
    localparam logic [5:0] S_TAP_ACC = 6'd26;
    localparam logic [5:0] S_TAP_END = 6'd39;
    localparam logic [5:0] S_DONE = 6'd40;

    localparam logic [2:0] H_FB = 3'd0;
    localparam logic [2:0] H_NGA = 3'd1;
    localparam logic [2:0] H_NGB = 3'd2;
    localparam logic [2:0] H_LP = 3'd3;
    localparam logic [2:0] H_DEC = 3'd4;
    localparam logic [2:0] H_APA = 3'd5;
    localparam logic [2:0] H_APB = 3'd6;

    localparam logic [3:0] RG_PD = 4'd0;
    localparam logic [3:0] RG_ID0 = 4'd1;
    localparam logic [3:0] RG_ID1 = 4'd2;
    localparam logic [3:0] RG_ID2 = 4'd3;
    localparam logic [3:0] RG_ID3 = 4'd4;
    localparam logic [3:0] RG_MD0 = 4'd5;
    localparam logic [3:0] RG_MD1 = 4'd6;
    localparam logic [3:0] RG_TD0 = 4'd7;
    localparam logic [3:0] RG_TD1 = 4'd8;
    localparam logic [3:0] RG_DF0 = 4'd9;
    localparam logic [3:0] RG_DF1 = 4'd10;
    localparam logic [3:0] RG_TL0 = 4'd11;
    localparam logic [3:0] RG_TL1 = 4'd12;

    typedef struct packed {
        logic              clr;
        logic [ADDR_W-1:0] clr_addr;
        logic              run;
        logic [5:0]        step;
        logic              accept;
        logic              load_out;
    } t_cmd;

    typedef struct packed {
        logic [3:0]  rg;
        logic [12:0] delay;
        logic        neg;
        logic        right;
    } t_tap;

    function automatic t_smp sat(t_wide v);
        t_smp r;
        if (v > SMP_HI) begin
            r = SMP_HI[SMP_W-1:0];
        end else if (v < SMP_LO) begin
            r = SMP_LO[SMP_W-1:0];
        end else begin
            r = v[SMP_W-1:0];
        end
        return r;
    endfunction

    // floor(v * c / 2^16)
    function automatic t_wide mulc(t_wide v, t_coef c);
        logic signed [43:0] p;
        p = v * $signed({1'b0, c});
        return p[42:16];
    endfunction

    function automatic logic [ADDR_W-1:0] mem_addr(logic [3:0] rg, logic [15:0] t,
                                                   logic [15:0] ofs);
        logic [15:0] i;
        logic [ADDR_W-1:0] a;
        i = t + ofs;
        case (rg)
            RG_PD:   a = 16'(i[12:0]);
            RG_ID0:  a = 16'd8192 + 16'(i[7:0]);
            RG_ID1:  a = 16'd8448 + 16'(i[6:0]);
            RG_ID2:  a = 16'd8576 + 16'(i[8:0]);
            RG_ID3:  a = 16'd9088 + 16'(i[8:0]);
            RG_MD0:  a = 16'd9600 + 16'(i[9:0]);
            RG_MD1:  a = 16'd10624 + 16'(i[9:0]);
            RG_TD0:  a = 16'd11648 + 16'(i[12:0]);
            RG_TD1:  a = 16'd19840 + 16'(i[12:0]);
            RG_DF0:  a = 16'd28032 + 16'(i[10:0]);
            RG_DF1:  a = 16'd30080 + 16'(i[11:0]);
            RG_TL0:  a = 16'd34176 + 16'(i[11:0]);
            RG_TL1:  a = 16'd38272 + 16'(i[11:0]);
            default: a = '0;
        endcase
        return a;
    endfunction

    function automatic logic [12:0] id_delay(logic [1:0] i);
        logic [12:0] d;
        unique case (i)
            2'd0: d = 13'd142;
            2'd1: d = 13'd107;
            2'd2: d = 13'd379;
            2'd3: d = 13'd277;
        endcase
        return d;
    endfunction

    function automatic logic [12:0] td_delay(logic h);
        return h ? 13'd4217 : 13'd4453;
    endfunction

    function automatic logic [12:0] df_delay(logic h);
        return h ? 13'd2656 : 13'd1800;
    endfunction

    function automatic logic [12:0] tl_delay(logic h);
        return h ? 13'd3163 : 13'd3720;
    endfunction

    function automatic t_tap tap_info(logic [3:0] k);
        t_tap r;
        case (k)
            4'd0:    r = '{RG_TD1, 13'd266, 1'b0, 1'b0};
            4'd1:    r = '{RG_TD1, 13'd2974, 1'b0, 1'b0};
            4'd2:    r = '{RG_DF1, 13'd1913, 1'b1, 1'b0};
            4'd3:    r = '{RG_TL1, 13'd1996, 1'b0, 1'b0};
            4'd4:    r = '{RG_TD0, 13'd1990, 1'b1, 1'b0};
            4'd5:    r = '{RG_DF0, 13'd187, 1'b1, 1'b0};
            4'd6:    r = '{RG_TL0, 13'd1066, 1'b0, 1'b0};
            4'd7:    r = '{RG_TD0, 13'd353, 1'b0, 1'b1};
            4'd8:    r = '{RG_TD0, 13'd3627, 1'b0, 1'b1};
            4'd9:    r = '{RG_DF0, 13'd1228, 1'b1, 1'b1};
            4'd10:   r = '{RG_TL0, 13'd2673, 1'b0, 1'b1};
            4'd11:   r = '{RG_TD1, 13'd2111, 1'b1, 1'b1};
            4'd12:   r = '{RG_DF1, 13'd335, 1'b1, 1'b1};
            4'd13:   r = '{RG_TL1, 13'd121, 1'b0, 1'b1};
            default: r = '{RG_PD, 13'd0, 1'b0, 1'b0};
        endcase
        return r;
    endfunction

endpackage

// ===== hw/rtl/plate_reverb_tank.sv =====
`timescale 1ns / 1ps
// A new request is taken only in the idle state, after the previous one has run all
// of its steps and its result has been loaded, one step per delay-memory access
// on a single dual-port memory (one write, one registered read per cycle).
// A finished result waits in an output register while the next request runs.
// Reset (sync, active low) clears the delay memory in one pass over every word;
// no request is taken until it ends. Config writes are taken at any time.
module plate_reverb_tank (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic signed [23:0]  i_sample_in,
    output logic                o_valid,
    input  logic                i_ready,
    output logic signed [26:0]  o_left_out,
    output logic signed [26:0]  o_right_out
);
    import prt_pkg::*;

    t_cmd cmd;

    prt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (cmd)
    );

    prt_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_sample_in (i_sample_in),
        .o_left_out  (o_left_out),
        .o_right_out (o_right_out)
    );
endmodule

// ===== hw/rtl/prt_ctrl.sv =====
`timescale 1ns / 1ps
module prt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    output logic          o_valid,
    input  logic          i_ready,
    output prt_pkg::t_cmd o_cmd
);
    import prt_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_RUN   = 3'b100
    } t_state;

    t_state            r_state, n_state;
    logic [5:0]        r_step, n_step;
    logic [ADDR_W-1:0] r_clr, n_clr;
    logic              r_ovalid, n_ovalid;

    always_comb begin
        n_state = r_state;
        n_step = r_step;
        n_clr = r_clr;
        o_cmd = '0;
        o_cmd.clr_addr = r_clr;
        o_cmd.step = r_step;
        o_ready = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr = 1'b1;
                n_clr = r_clr + 16'd1;
                if (r_clr == 16'(MEM_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_step = S_PD_WR;
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                o_cmd.run = 1'b1;
                if (r_step == S_DONE) begin
                    if (!r_ovalid || i_ready) begin
                        o_cmd.load_out = 1'b1;
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_step = r_step + 6'd1;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
        if (o_cmd.load_out) begin
            n_ovalid = 1'b1;
        end else if (i_ready) begin
            n_ovalid = 1'b0;
        end else begin
            n_ovalid = r_ovalid;
        end
    end

    assign o_valid = r_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_step <= '0;
            r_clr <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step <= n_step;
            r_clr <= n_clr;
            r_ovalid <= n_ovalid;
        end
    end
endmodule

// ===== hw/rtl/prt_dp.sv =====
`timescale 1ns / 1ps
module prt_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  prt_pkg::t_cmd        i_cmd,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_data,
    input  logic signed [23:0]   i_sample_in,
    output logic signed [26:0]   o_left_out,
    output logic signed [26:0]   o_right_out
);
    import prt_pkg::*;

    logic [12:0] r_predelay;
    t_coef       r_prefilt, r_diff1, r_diff2, r_decay, r_ddiff, r_damp;

    logic [15:0] r_t, n_t;
    logic [9:0]  r_off0, n_off0, r_off1, n_off1;
    t_smp        r_lp0, n_lp0, r_lp1, n_lp1, r_lp2, n_lp2;
    t_smp        r_x, n_x, r_y, n_y, r_d, n_d, r_v, n_v, r_smp, r_rd;
    t_wide       r_l, n_l, r_r, n_r;

    logic [23:0] r_mem [0:MEM_DEPTH-1];
    logic [ADDR_W-1:0] raddr, waddr;
    logic        we;
    t_smp        wdata;

    t_wide mul_a, mul_p, rd_w;
    t_coef mul_c;

    logic [5:0]  s;
    logic        in_id, id_b, in_half, h;
    logic [1:0]  id_i;
    logic [5:0]  s_id, s_h, s_k;
    logic [2:0]  rel;
    logic [12:0] pd;
    logic [16:0] dd2_sum;
    t_coef       dd2, id_g;
    t_smp        lp_h, sv;
    t_tap        tap_rd, tap_acc;

    assign s = i_cmd.step;
    assign s_id = s - S_ID_FIRST;
    assign in_id = (s >= S_ID_FIRST) && (s <= S_ID_LAST);
    assign id_i = s_id[2:1];
    assign id_b = s_id[0];
    assign in_half = (s >= S_H0) && (s <= S_H_END);
    assign h = (s >= S_H1);
    assign s_h = h ? (s - S_H1) : (s - S_H0);
    assign rel = s_h[2:0];
    assign pd = (r_predelay > PREDELAY_MAX) ? PREDELAY_MAX : r_predelay;
    assign dd2_sum = {1'b0, r_decay} + DD2_BIAS;
    assign dd2 = (dd2_sum < DD2_LO) ? DD2_LO[15:0] :
                 (dd2_sum > DD2_HI) ? DD2_HI[15:0] : dd2_sum[15:0];
    assign id_g = (id_i < 2'd2) ? r_diff1 : r_diff2;
    assign lp_h = h ? r_lp2 : r_lp1;
    assign rd_w = WIDE_W'(r_rd);
    assign tap_rd = tap_info(4'(s - S_TAP_RD));
    assign s_k = s - S_TAP_ACC;
    assign tap_acc = tap_info(s_k[3:0]);

    always_comb begin
        mul_a = '0;
        mul_c = '0;
        if (s == S_LP_IN) begin
            mul_a = rd_w - WIDE_W'(r_lp0);
            mul_c = r_prefilt;
        end else if (in_id) begin
            mul_a = id_b ? WIDE_W'(r_v) : rd_w;
            mul_c = id_g;
        end else if (in_half) begin
            case (rel)
                H_FB:    begin mul_a = rd_w; mul_c = r_decay; end
                H_NGA:   begin mul_a = rd_w; mul_c = r_ddiff; end
                H_NGB:   begin mul_a = WIDE_W'(r_v); mul_c = r_ddiff; end
                H_LP:    begin mul_a = rd_w - WIDE_W'(lp_h); mul_c = r_damp; end
                H_DEC:   begin mul_a = WIDE_W'(r_y); mul_c = r_decay; end
                H_APA:   begin mul_a = rd_w; mul_c = dd2; end
                H_APB:   begin mul_a = WIDE_W'(r_v); mul_c = dd2; end
                default: begin mul_a = '0; mul_c = '0; end
            endcase
        end
    end

    assign mul_p = mulc(mul_a, mul_c);

    always_comb begin
        raddr = '0;
        we = 1'b0;
        waddr = '0;
        wdata = '0;
        sv = '0;
        n_t = r_t;
        n_off0 = r_off0;
        n_off1 = r_off1;
        n_lp0 = r_lp0;
        n_lp1 = r_lp1;
        n_lp2 = r_lp2;
        n_x = r_x;
        n_y = r_y;
        n_d = r_d;
        n_v = r_v;
        n_l = r_l;
        n_r = r_r;
        if (i_cmd.clr) begin
            we = 1'b1;
            waddr = i_cmd.clr_addr;
        end else if (i_cmd.run) begin
            if (s == S_PD_WR) begin
                we = 1'b1;
                waddr = mem_addr(RG_PD, r_t, 16'd0);
                wdata = r_smp;
                if (r_t[10:0] == 11'd0) begin
                    n_off0 = r_off0 + (r_t[15] ? 10'd1 : 10'd1023);
                    n_off1 = r_off1 + (r_t[15] ? 10'd1 : 10'd1023);
                end
            end else if (s == S_PD_RD) begin
                raddr = mem_addr(RG_PD, r_t, -{3'b000, pd});
            end else if (s == S_LP_IN) begin
                sv = sat(WIDE_W'(r_lp0) + mul_p);
                n_x = sv;
                n_lp0 = sv;
                raddr = mem_addr(RG_ID0, r_t, -{3'b000, id_delay(2'd0)});
            end else if (in_id) begin
                if (!id_b) begin
                    sv = sat(WIDE_W'(r_x) - mul_p);
                    we = 1'b1;
                    waddr = mem_addr(RG_ID0 + 4'(id_i), r_t, 16'd0);
                    wdata = sv;
                    n_v = sv;
                    n_d = r_rd;
                end else begin
                    n_x = sat(WIDE_W'(r_d) + mul_p);
                    if (id_i != 2'd3) begin
                        raddr = mem_addr(RG_ID1 + 4'(id_i), r_t,
                                         -{3'b000, id_delay(id_i + 2'd1)});
                    end else begin
                        raddr = mem_addr(RG_TL1, r_t, -{3'b000, tl_delay(1'b1)});
                    end
                end
            end else if (in_half) begin
                case (rel)
                    H_FB: begin
                        n_y = sat(WIDE_W'(r_x) + mul_p);
                        raddr = mem_addr(RG_MD0 + 4'(h), r_t,
                                         {6'd0, (h ? r_off1 : r_off0)});
                    end
                    H_NGA: begin
                        sv = sat(WIDE_W'(r_y) + mul_p);
                        we = 1'b1;
                        waddr = mem_addr(RG_MD0 + 4'(h), r_t, 16'd0);
                        wdata = sv;
                        n_v = sv;
                        n_d = r_rd;
                    end
                    H_NGB: begin
                        sv = sat(WIDE_W'(r_d) - mul_p);
                        we = 1'b1;
                        waddr = mem_addr(RG_TD0 + 4'(h), r_t, 16'd0);
                        wdata = sv;
                        n_y = sv;
                        raddr = mem_addr(RG_TD0 + 4'(h), r_t, -{3'b000, td_delay(h)});
                    end
                    H_LP: begin
                        sv = sat(WIDE_W'(lp_h) + mul_p);
                        n_y = sv;
                        if (h) begin
                            n_lp2 = sv;
                        end else begin
                            n_lp1 = sv;
                        end
                    end
                    H_DEC: begin
                        n_y = mul_p[SMP_W-1:0];
                        raddr = mem_addr(RG_DF0 + 4'(h), r_t, -{3'b000, df_delay(h)});
                    end
                    H_APA: begin
                        sv = sat(WIDE_W'(r_y) - mul_p);
                        we = 1'b1;
                        waddr = mem_addr(RG_DF0 + 4'(h), r_t, 16'd0);
                        wdata = sv;
                        n_v = sv;
                        n_d = r_rd;
                    end
                    H_APB: begin
                        sv = sat(WIDE_W'(r_d) + mul_p);
                        we = 1'b1;
                        waddr = mem_addr(RG_TL0 + 4'(h), r_t, 16'd0);
                        wdata = sv;
                        if (!h) begin
                            raddr = mem_addr(RG_TL0, r_t, -{3'b000, tl_delay(1'b0)});
                        end else begin
                            n_t = r_t + 16'd1;
                            n_l = '0;
                            n_r = '0;
                        end
                    end
                    default: ;
                endcase
            end else begin
                if ((s >= S_TAP_RD) && (s <= S_TAP_RD_END)) begin
                    raddr = mem_addr(tap_rd.rg, r_t, -{3'b000, tap_rd.delay});
                end
                if ((s >= S_TAP_ACC) && (s <= S_TAP_END)) begin
                    if (tap_acc.right) begin
                        n_r = tap_acc.neg ? (r_r - rd_w) : (r_r + rd_w);
                    end else begin
                        n_l = tap_acc.neg ? (r_l - rd_w) : (r_l + rd_w);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        r_rd <= r_mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_predelay <= 13'd480;
            r_prefilt <= 16'd55706;
            r_diff1 <= 16'd49152;
            r_diff2 <= 16'd40960;
            r_decay <= 16'd49152;
            r_ddiff <= 16'd45875;
            r_damp <= 16'd62259;
            r_t <= '0;
            r_off0 <= 10'd352;
            r_off1 <= 10'd116;
            r_lp0 <= '0;
            r_lp1 <= '0;
            r_lp2 <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PREDELAY:   r_predelay <= i_cfg_data[12:0];
                    CFG_PREFILT:    r_prefilt <= i_cfg_data;
                    CFG_DIFF_ONE:   r_diff1 <= i_cfg_data;
                    CFG_DIFF_TWO:   r_diff2 <= i_cfg_data;
                    CFG_DECAY:      r_decay <= i_cfg_data;
                    CFG_DECAY_DIFF: r_ddiff <= i_cfg_data;
                    CFG_DAMPING:    r_damp <= i_cfg_data;
                    default: ;
                endcase
            end
            r_t <= n_t;
            r_off0 <= n_off0;
            r_off1 <= n_off1;
            r_lp0 <= n_lp0;
            r_lp1 <= n_lp1;
            r_lp2 <= n_lp2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_y <= n_y;
        r_d <= n_d;
        r_v <= n_v;
        r_l <= n_l;
        r_r <= n_r;
        if (i_cmd.accept) begin
            r_smp <= i_sample_in;
        end
        if (i_cmd.load_out) begin
            o_left_out <= r_l;
            o_right_out <= r_r;
        end
    end
endmodule

// ===== test/plate_reverb_tank_tb.sv =====
`timescale 1ns / 1ps
module plate_reverb_tank_tb;
    import prt_pkg::*;

    localparam int IDLE_LIMIT = 250000;
    localparam int B_PD = 0;
    localparam int B_ID0 = 8192;
    localparam int B_ID1 = 8448;
    localparam int B_ID2 = 8576;
    localparam int B_ID3 = 9088;
    localparam int B_MD0 = 9600;
    localparam int B_MD1 = 10624;
    localparam int B_TD0 = 11648;
    localparam int B_TD1 = 19840;
    localparam int B_DF0 = 28032;
    localparam int B_DF1 = 30080;
    localparam int B_TL0 = 34176;
    localparam int B_TL1 = 38272;
    localparam int LINE_WORDS = 42368;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    t_smp        i_sample_in = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    t_wide       o_left_out;
    t_wide       o_right_out;

    plate_reverb_tank u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_sample_in(i_sample_in),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_left_out(o_left_out),
        .o_right_out(o_right_out)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // reverb model state
    int unsigned rv_reg[7];
    int          line_mem[LINE_WORDS];
    int unsigned rv_count;
    int unsigned mod_ofs[2];
    longint      lp_state[3];

    t_wide left_q[$];
    t_wide right_q[$];
    int    n_fail = 0;
    int    n_req = 0;
    int    n_out = 0;
    int    idle_cycles = 0;
    bit    rx_free = 1'b1;
    int    hold_req = 0;

    function automatic longint clip(longint v);
        if (v > 8388607) return 8388607;
        if (v < -8388608) return -8388608;
        return v;
    endfunction

    function automatic longint scale(longint v, int unsigned c);
        return (v * longint'(c)) >>> 16;
    endfunction

    function automatic int unsigned wrap(int unsigned t, int unsigned d, int unsigned m);
        return (t - d) & m;
    endfunction

    function automatic longint allpass(int base, int unsigned m, int unsigned t,
                                       int unsigned d, longint x, int unsigned g, bit neg);
        longint rd;
        longint v;
        rd = line_mem[base + wrap(t, d, m)];
        v = neg ? clip(x + scale(rd, g)) : clip(x - scale(rd, g));
        line_mem[base + (t & m)] = int'(v);
        return neg ? clip(rd - scale(v, g)) : clip(rd + scale(v, g));
    endfunction

    function automatic longint smooth(int k, longint x, int unsigned c);
        lp_state[k] = clip(lp_state[k] + scale(x - lp_state[k], c));
        return lp_state[k];
    endfunction

    function automatic longint rd_line(int base, int unsigned t, int unsigned d,
                                       int unsigned m);
        return line_mem[base + wrap(t, d, m)];
    endfunction

    function automatic void reverb_reset();
        rv_reg = '{480, 55706, 49152, 40960, 49152, 45875, 62259};
        foreach (line_mem[i]) line_mem[i] = 0;
        rv_count = 0;
        mod_ofs = '{352, 116};
        lp_state = '{0, 0, 0};
    endfunction

    function automatic void reverb_step(t_smp s);
        int unsigned t;
        int unsigned pd;
        int unsigned dec;
        int unsigned dd2;
        int unsigned step;
        longint x;
        longint y;
        longint fb[2];
        longint l;
        longint r;
        int td_b[2];
        int df_b[2];
        int tl_b[2];
        int md_b[2];
        int unsigned df_m[2];
        int unsigned td_d[2];
        int unsigned df_d[2];
        td_b = '{B_TD0, B_TD1};
        df_b = '{B_DF0, B_DF1};
        tl_b = '{B_TL0, B_TL1};
        md_b = '{B_MD0, B_MD1};
        df_m = '{2047, 4095};
        td_d = '{4453, 4217};
        df_d = '{1800, 2656};
        t = rv_count;
        pd = rv_reg[0] > 4800 ? 4800 : rv_reg[0];
        dec = rv_reg[4];
        dd2 = dec + 9830;
        dd2 = dd2 < 16384 ? 16384 : (dd2 > 32768 ? 32768 : dd2);
        if ((t & 2047) == 0) begin
            step = t < 32768 ? 1023 : 1;
            mod_ofs[0] = (mod_ofs[0] + step) & 1023;
            mod_ofs[1] = (mod_ofs[1] + step) & 1023;
        end
        line_mem[B_PD + (t & 8191)] = int'(s);
        x = rd_line(B_PD, t, pd, 8191);
        x = smooth(0, x, rv_reg[1]);
        x = allpass(B_ID0, 255, t, 142, x, rv_reg[2], 1'b0);
        x = allpass(B_ID1, 127, t, 107, x, rv_reg[2], 1'b0);
        x = allpass(B_ID2, 511, t, 379, x, rv_reg[3], 1'b0);
        x = allpass(B_ID3, 511, t, 277, x, rv_reg[3], 1'b0);
        fb[0] = rd_line(B_TL1, t, 3163, 4095);
        fb[1] = rd_line(B_TL0, t, 3720, 4095);
        for (int h = 0; h < 2; h++) begin
            y = clip(x + scale(fb[h], dec));
            // modulated all-pass reads ahead by the moving offset
            y = allpass(md_b[h], 1023, t, (0 - mod_ofs[h]), y, rv_reg[5], 1'b1);
            line_mem[td_b[h] + (t & 8191)] = int'(y);
            y = rd_line(td_b[h], t, td_d[h], 8191);
            y = smooth(1 + h, y, rv_reg[6]);
            y = scale(y, dec);
            y = allpass(df_b[h], df_m[h], t, df_d[h], y, dd2, 1'b0);
            line_mem[tl_b[h] + (t & 4095)] = int'(y);
        end
        rv_count = (rv_count + 1) & 16'hffff;
        t = rv_count;
        l = rd_line(B_TD1, t, 266, 8191) + rd_line(B_TD1, t, 2974, 8191)
            - rd_line(B_DF1, t, 1913, 4095) + rd_line(B_TL1, t, 1996, 4095)
            - rd_line(B_TD0, t, 1990, 8191) - rd_line(B_DF0, t, 187, 2047)
            + rd_line(B_TL0, t, 1066, 4095);
        r = rd_line(B_TD0, t, 353, 8191) + rd_line(B_TD0, t, 3627, 8191)
            - rd_line(B_DF0, t, 1228, 2047) + rd_line(B_TL0, t, 2673, 4095)
            - rd_line(B_TD1, t, 2111, 8191) - rd_line(B_DF1, t, 335, 4095)
            + rd_line(B_TL1, t, 121, 4095);
        left_q.push_back(t_wide'(l));
        right_q.push_back(t_wide'(r));
    endfunction

    // caller sits at a falling edge; returns at a falling edge
    task automatic send_sample(t_smp s);
        i_valid = 1'b1;
        i_sample_in = s;
        do @(posedge i_clk); while (!o_ready);
        reverb_step(s);
        n_req++;
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    task automatic drain();
        wait (left_q.size() == 0);
        repeat (60) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] ix, logic [15:0] val);
        i_cfg_we = 1'b1;
        i_cfg_index = ix;
        i_cfg_data = val;
        if (ix == CFG_PREDELAY) rv_reg[0] = val & 16'h1fff;
        else if (ix <= CFG_DAMPING) rv_reg[ix] = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    function automatic t_smp rand_sample();
        case ($urandom_range(0, 7))
            0: return 24'sh7fffff;
            1: return 24'sh800000;
            2: return t_smp'($signed($urandom_range(0, 4095)) - 2048);
            default: return t_smp'($urandom);
        endcase
    endfunction

    task automatic send_bursts(int count);
        int burst;
        burst = 0;
        for (int k = 0; k < count; k++) begin
            send_sample(rand_sample());
            if (burst == 0) begin
                burst = $urandom_range(1, 30);
                repeat ($urandom_range(0, 60)) @(negedge i_clk);
            end else begin
                burst--;
            end
        end
    endtask

    always @(negedge i_clk) begin
        if (hold_req > 0) begin
            i_ready = 1'b0;
            hold_req--;
        end else if (rx_free) begin
            i_ready = 1'b1;
        end else begin
            i_ready = ($urandom_range(0, 3) != 0) || (($urandom_range(0, 40) == 0));
        end
    end

    always @(posedge i_clk) begin
        if (o_valid && i_ready) begin
            n_out++;
            if (left_q.size() == 0) begin
                $error("result with nothing expected: left %0d right %0d",
                       o_left_out, o_right_out);
                n_fail++;
            end else begin
                if (o_left_out !== left_q[0]) begin
                    $error("left_out expected %0d actual %0d", left_q[0], o_left_out);
                    n_fail++;
                end
                if (o_right_out !== right_q[0]) begin
                    $error("right_out expected %0d actual %0d", right_q[0], o_right_out);
                    n_fail++;
                end
                void'(left_q.pop_front());
                void'(right_q.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if ((o_valid && i_ready) || (i_valid && o_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic test_directed();
        t_smp edge_vals[6];
        edge_vals = '{24'sh7fffff, 24'sh800000, 24'sh000000, 24'shffffff, 24'sh000001,
                      24'sh555555};
        write_reg(CFG_PREDELAY, 16'd0);
        foreach (edge_vals[k]) send_sample(edge_vals[k]);
        send_sample(24'sh7fffff);
        repeat (12) send_sample(24'sh000000);
        drain();
    endtask

    task automatic test_registers();
        // extremes, unused index, and bits above the predelay width
        write_reg(CFG_PREDELAY, 16'hffff);
        write_reg(CFG_PREFILT, 16'hffff);
        write_reg(CFG_DIFF_ONE, 16'hffff);
        write_reg(CFG_DIFF_TWO, 16'hffff);
        write_reg(CFG_DECAY, 16'hffff);
        write_reg(CFG_DECAY_DIFF, 16'hffff);
        write_reg(CFG_DAMPING, 16'hffff);
        write_reg(3'd7, 16'h1234);
        send_bursts(150);
        drain();
        write_reg(CFG_PREDELAY, 16'd1);
        write_reg(CFG_PREFILT, 16'd0);
        write_reg(CFG_DIFF_ONE, 16'd0);
        write_reg(CFG_DIFF_TWO, 16'd0);
        write_reg(CFG_DECAY, 16'd0);
        write_reg(CFG_DECAY_DIFF, 16'd0);
        write_reg(CFG_DAMPING, 16'd0);
        send_bursts(150);
        drain();
        write_reg(CFG_PREDELAY, 16'd4800);
        write_reg(CFG_DECAY, 16'd30000);
        write_reg(CFG_PREFILT, 16'd65535);
        write_reg(CFG_DAMPING, 16'd65535);
        send_bursts(100);
        drain();
    endtask

    task automatic test_random();
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(CFG_PREDELAY, 16'($urandom_range(0, 120)));
            write_reg(CFG_PREFILT, 16'($urandom));
            write_reg(CFG_DIFF_ONE, 16'($urandom));
            write_reg(CFG_DIFF_TWO, 16'($urandom));
            write_reg(CFG_DECAY, 16'($urandom_range(40000, 65535)));
            write_reg(CFG_DECAY_DIFF, 16'($urandom));
            write_reg(CFG_DAMPING, 16'($urandom));
            rx_free = ph[0];
            send_bursts(220);
            drain();
        end
        rx_free = 1'b0;
    endtask

    task automatic test_backpressure();
        hold_req = 800;
        repeat (20) send_sample(rand_sample());
        wait (left_q.size() == 0);
        repeat (20) send_sample(rand_sample());
        rx_free = 1'b1;
        drain();
    endtask

    initial begin
        reverb_reset();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_registers();
        test_random();
        test_backpressure();
        $display("Covered %0d samples and %0d wet results across extreme and random",
                 n_req, n_out);
        $display("coefficient settings, with bursty input and output stalls.");
        if (n_fail == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
